@@ design/rdq_pkg.sv @@
package rdq_pkg;

  parameter int unsigned RdqDepth = 64;

  parameter int unsigned IdW     = 32;
  parameter int unsigned SalaryW = 32;
  parameter int unsigned PhoneW  = 34;
  parameter int unsigned RecW    = IdW + SalaryW + PhoneW;

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_LIST       = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

@@ design/record_double_ended_queue.sv @@
// Bounded double-ended queue of records (id, salary in cents, phone) held in a
// ring buffer of DEPTH slots in one single-port RAM with registered read.
// Push front/back answers ok, or full at capacity; pop front/back returns the
// removed record, or empty; list streams every record front to back with last
// set on the final word, or a single empty word. Every word carries the count
// held after the operation. Push and pop need no extra state and may follow
// each other directly; a list makes one RAM read per record, with the input
// held off until the last word is issued. Input is held off while an
// unaccepted result word is pending. Func codes 5 to 7 are accepted and
// dropped without a result.
module record_double_ended_queue
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = RdqDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       func_i,
  input  logic signed [IdW-1:0]            employee_id_i,
  input  logic [SalaryW-1:0]               salary_cents_i,
  input  logic [PhoneW-1:0]                phone_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic signed [IdW-1:0]            out_id_o,
  output logic [SalaryW-1:0]               out_salary_o,
  output logic [PhoneW-1:0]                out_phone_o,
  output logic [$clog2(DEPTH+1)-1:0]       entries_o,
  output logic                             last_o
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(DEPTH);
  localparam logic [CntW:0]    DepthSum = (CntW + 1)'(DEPTH);
  localparam logic [AddrW-1:0] LastSlot = AddrW'(DEPTH - 1);

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_e;

  state_e           state_q;
  logic [AddrW-1:0] head_q;
  logic [CntW-1:0]  count_q;
  logic [CntW-1:0]  idx_q;
  logic             out_valid_q;
  logic             out_valid_d;
  logic             has_rec_q;
  logic             last_q;
  status_e          status_q;
  logic [CntW-1:0]  entries_q;

  logic             accept;
  logic             out_free;
  logic             word_issue;
  logic             full;
  logic             empty;
  func_e            func;
  logic [AddrW-1:0] head_dec;
  logic [AddrW-1:0] head_inc;
  logic [AddrW-1:0] back_slot;
  logic [AddrW-1:0] tail_slot;
  logic [AddrW-1:0] list_slot;
  logic             list_last;

  logic             mem_we;
  logic             mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [RecW-1:0]  mem_wdata;
  logic [RecW-1:0]  mem_rdata;

  function automatic logic [AddrW-1:0] slot_of(logic [AddrW-1:0] base,
                                               logic [CntW-1:0] off);
    logic [CntW:0] sum;
    sum = (CntW + 1)'(base) + (CntW + 1)'(off);
    if (sum >= DepthSum) begin
      sum = sum - DepthSum;
    end
    return sum[AddrW-1:0];
  endfunction

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign func       = func_e'(func_i);
  assign full       = (count_q == DepthCnt);
  assign empty      = (count_q == '0);

  // a new word goes out on push/pop, on list of an empty queue, or per list step
  assign word_issue  = (state_q == S_LIST) ? out_free
                     : accept && (func_i <= FUNC_LIST) && ((func != FUNC_LIST) || empty);
  assign out_valid_d = word_issue || (out_valid_q && !out_ready_i);

  assign head_dec  = (head_q == '0) ? LastSlot : head_q - 1'b1;
  assign head_inc  = slot_of(head_q, CntW'(1));
  assign back_slot = slot_of(head_q, count_q);
  assign tail_slot = slot_of(head_q, count_q - 1'b1);
  assign list_slot = slot_of(head_q, idx_q);
  assign list_last = (idx_q == count_q - 1'b1);

  assign mem_wdata = {employee_id_i, salary_cents_i, phone_i};

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = head_q;
    if (state_q == S_LIST) begin
      mem_re   = out_free;
      mem_addr = list_slot;
    end else if (accept) begin
      unique case (func)
        FUNC_PUSH_FRONT: begin
          mem_we   = !full;
          mem_addr = head_dec;
        end
        FUNC_PUSH_BACK: begin
          mem_we   = !full;
          mem_addr = back_slot;
        end
        FUNC_POP_FRONT: begin
          mem_re   = !empty;
          mem_addr = head_q;
        end
        FUNC_POP_BACK: begin
          mem_re   = !empty;
          mem_addr = tail_slot;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      has_rec_q   <= 1'b0;
      last_q      <= 1'b0;
      status_q    <= ST_OK;
      entries_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
                has_rec_q   <= 1'b0;
                last_q      <= 1'b1;
                if (full) begin
                  status_q  <= ST_FULL;
                  entries_q <= count_q;
                end else begin
                  status_q  <= ST_OK;
                  count_q   <= count_q + 1'b1;
                  entries_q <= count_q + 1'b1;
                  if (func == FUNC_PUSH_FRONT) begin
                    head_q <= head_dec;
                  end
                end
              end
              FUNC_POP_FRONT, FUNC_POP_BACK: begin
                last_q      <= 1'b1;
                if (empty) begin
                  status_q  <= ST_EMPTY;
                  has_rec_q <= 1'b0;
                  entries_q <= '0;
                end else begin
                  status_q  <= ST_OK;
                  has_rec_q <= 1'b1;
                  count_q   <= count_q - 1'b1;
                  entries_q <= count_q - 1'b1;
                  if (func == FUNC_POP_FRONT) begin
                    head_q <= head_inc;
                  end
                end
              end
              FUNC_LIST: begin
                if (empty) begin
                  status_q    <= ST_EMPTY;
                  has_rec_q   <= 1'b0;
                  last_q      <= 1'b1;
                  entries_q   <= '0;
                end else begin
                  state_q <= S_LIST;
                  idx_q   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_LIST: begin
          if (out_free) begin
            status_q    <= ST_OK;
            has_rec_q   <= 1'b1;
            last_q      <= list_last;
            entries_q   <= count_q;
            idx_q       <= idx_q + 1'b1;
            if (list_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  rdq_ram #(
    .Width (RecW),
    .Depth (DEPTH)
  ) u_rdq_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign entries_o    = entries_q;
  assign last_o       = last_q;
  assign out_id_o     = has_rec_q ? $signed(mem_rdata[RecW-1 -: IdW]) : '0;
  assign out_salary_o = has_rec_q ? mem_rdata[SalaryW+PhoneW-1 -: SalaryW] : '0;
  assign out_phone_o  = has_rec_q ? mem_rdata[PhoneW-1:0] : '0;

endmodule

@@ design/rdq_ram.sv @@
module rdq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/rdq_checker.sv @@
module rdq_assert
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = RdqDepth
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [2:0]                  func_i,
  input logic signed [IdW-1:0]       employee_id_i,
  input logic [SalaryW-1:0]          salary_cents_i,
  input logic [PhoneW-1:0]           phone_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [1:0]                  status_o,
  input logic signed [IdW-1:0]       out_id_o,
  input logic [SalaryW-1:0]          out_salary_o,
  input logic [PhoneW-1:0]           out_phone_o,
  input logic [$clog2(DEPTH+1)-1:0]  entries_o,
  input logic                        last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_id_o)
      && $stable(out_phone_o) && $stable(last_o))
    else $error("result word changed while stalled");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entries_o <= DepthCnt)
    else $error("count beyond capacity");

  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> entries_o == DepthCnt && last_o)
    else $error("full status without full count");

  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> entries_o == '0 && last_o
      && out_id_o == '0 && out_phone_o == '0)
    else $error("empty status malformed");

endmodule

bind record_double_ended_queue rdq_assert #(.DEPTH(DEPTH)) u_rdq_assert (.*);

@@ tb/rdq_checker.sv @@
`timescale 1ns / 100ps

module rdq_checker
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = RdqDepth,
  parameter int unsigned EntW  = $clog2(DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [2:0]            func_i,
  input  logic signed [IdW-1:0] employee_id_i,
  input  logic [SalaryW-1:0]    salary_cents_i,
  input  logic [PhoneW-1:0]     phone_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [1:0]            status_i,
  input  logic signed [IdW-1:0] out_id_i,
  input  logic [SalaryW-1:0]    out_salary_i,
  input  logic [PhoneW-1:0]     out_phone_i,
  input  logic [EntW-1:0]       entries_i,
  input  logic                  last_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct {
    status_e               status;
    logic signed [IdW-1:0] id;
    logic [SalaryW-1:0]    salary;
    logic [PhoneW-1:0]     phone;
    logic [EntW-1:0]       entries;
    logic                  last;
  } result_word_t;

  logic signed [IdW-1:0] id_mem     [DEPTH];
  logic [SalaryW-1:0]    salary_mem [DEPTH];
  logic [PhoneW-1:0]     phone_mem  [DEPTH];
  int unsigned           front_slot = 0;
  int unsigned           held       = 0;

  result_word_t expected_words[$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic queue_word(input status_e st, input int unsigned slot, input bit with_rec,
                            input bit fin);
    result_word_t w;
    w.status  = st;
    w.id      = with_rec ? id_mem[slot] : '0;
    w.salary  = with_rec ? salary_mem[slot] : '0;
    w.phone   = with_rec ? phone_mem[slot] : '0;
    w.entries = EntW'(held);
    w.last    = fin;
    expected_words.push_back(w);
  endtask

  task automatic apply_operation(input logic [2:0] f, input logic signed [IdW-1:0] id,
                                 input logic [SalaryW-1:0] sal, input logic [PhoneW-1:0] ph);
    int unsigned slot;
    case (f)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (held >= DEPTH) begin
          queue_word(ST_FULL, 0, 1'b0, 1'b1);
        end else begin
          if (f == FUNC_PUSH_FRONT) begin
            front_slot = (front_slot == 0) ? DEPTH - 1 : front_slot - 1;
            slot = front_slot;
          end else begin
            slot = (front_slot + held) % DEPTH;
          end
          id_mem[slot]     = id;
          salary_mem[slot] = sal;
          phone_mem[slot]  = ph;
          held++;
          queue_word(ST_OK, 0, 1'b0, 1'b1);
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK: begin
        if (held == 0) begin
          queue_word(ST_EMPTY, 0, 1'b0, 1'b1);
        end else begin
          if (f == FUNC_POP_FRONT) begin
            slot = front_slot;
            front_slot = (front_slot + 1) % DEPTH;
          end else begin
            slot = (front_slot + held - 1) % DEPTH;
          end
          held--;
          queue_word(ST_OK, slot, 1'b1, 1'b1);
        end
      end
      FUNC_LIST: begin
        if (held == 0) begin
          queue_word(ST_EMPTY, 0, 1'b0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < held; i++) begin
            queue_word(ST_OK, (front_slot + i) % DEPTH, 1'b1, i + 1 == held);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    result_word_t w;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        apply_operation(func_i, employee_id_i, salary_cents_i, phone_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: status %0d entries %0d last %0d", status_i, entries_i,
                 last_i);
          fail_count_o++;
        end else begin
          w = expected_words.pop_front();
          if (status_i !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, status_i);
            fail_count_o++;
          end
          if (out_id_i !== w.id) begin
            $error("out_id: expected %0d, got %0d", w.id, out_id_i);
            fail_count_o++;
          end
          if (out_salary_i !== w.salary) begin
            $error("out_salary: expected %0d, got %0d", w.salary, out_salary_i);
            fail_count_o++;
          end
          if (out_phone_i !== w.phone) begin
            $error("out_phone: expected %0d, got %0d", w.phone, out_phone_i);
            fail_count_o++;
          end
          if (entries_i !== w.entries) begin
            $error("entries: expected %0d, got %0d", w.entries, entries_i);
            fail_count_o++;
          end
          if (last_i !== w.last) begin
            $error("last: expected %0d, got %0d", w.last, last_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_words.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import rdq_pkg::*;

  localparam int unsigned EntW         = $clog2(RdqDepth + 1);
  localparam int unsigned N_ITEMS      = 200;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam logic [2:0]  FUNC_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  FUNC_UNUSED_LAST  = 3'd7;
  localparam logic [PhoneW-1:0] PHONE_MAX   = 34'd9999999999;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [2:0]            func       = '0;
  logic signed [IdW-1:0] emp_id     = '0;
  logic [SalaryW-1:0]    salary     = '0;
  logic [PhoneW-1:0]     phone      = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [1:0]            status;
  logic signed [IdW-1:0] out_id;
  logic [SalaryW-1:0]    out_salary;
  logic [PhoneW-1:0]     out_phone;
  logic [EntW-1:0]       entries;
  logic                  last_word;

  int          fail_count;
  int          pending;
  int unsigned items_sent  = 0;
  int unsigned level       = 0;
  int unsigned burst_left  = 1;
  int unsigned idle_cycles = 0;
  int unsigned rx_tick     = 0;
  int unsigned rx_mode     = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  record_double_ended_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .employee_id_i (emp_id),
    .salary_cents_i(salary),
    .phone_i       (phone),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .out_id_o      (out_id),
    .out_salary_o  (out_salary),
    .out_phone_o   (out_phone),
    .entries_o     (entries),
    .last_o        (last_word)
  );

  rdq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .func_i        (func),
    .employee_id_i (emp_id),
    .salary_cents_i(salary),
    .phone_i       (phone),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .out_id_i      (out_id),
    .out_salary_i  (out_salary),
    .out_phone_i   (out_phone),
    .entries_i     (entries),
    .last_i        (last_word),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // receiver: stall style is redrawn at random from four modes
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 40 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_tick % 5) < 3;
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [PhoneW-1:0] rand_phone();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return PhoneW'(r % 64'd10000000000);
  endfunction

  task automatic send_word(input logic [2:0] f, input logic signed [IdW-1:0] id,
                           input logic [SalaryW-1:0] sal, input logic [PhoneW-1:0] ph);
    in_valid <= 1'b1;
    func     <= f;
    emp_id   <= id;
    salary   <= sal;
    phone    <= ph;
    do @(posedge clk_i); while (!in_ready);
    case (f)
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: if (level < RdqDepth) level++;
      FUNC_POP_FRONT, FUNC_POP_BACK:   if (level > 0) level--;
      default: ;
    endcase
    if (f <= FUNC_LIST) items_sent++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_random(input logic [2:0] f);
    send_word(f, $urandom, $urandom, rand_phone());
  endtask

  task automatic push_any();
    send_random($urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_BACK);
  endtask

  task automatic pop_any();
    send_random($urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_BACK);
  endtask

  initial begin
    int unsigned roll;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue on every read path
    send_word(FUNC_POP_FRONT, 0, 0, 0);
    send_word(FUNC_POP_BACK, 0, 0, 0);
    send_word(FUNC_LIST, 0, 0, 0);
    // field extremes, front push wraps the head below slot zero
    send_word(FUNC_PUSH_BACK, 32'sh8000_0000, '0, '0);
    send_word(FUNC_PUSH_FRONT, 32'sh7fff_ffff, '1, PHONE_MAX);
    send_word(FUNC_PUSH_BACK, -1, 32'd1, 34'd1);
    send_word(FUNC_PUSH_FRONT, 0, 32'h5555_5555, 34'h1_5555_5555);
    send_word(FUNC_LIST, 0, 0, 0);
    send_word(FUNC_UNUSED_FIRST, 0, 0, 0);
    send_word(FUNC_UNUSED_LAST, -1, '1, '1);
    send_word(FUNC_UNUSED_FIRST + 3'd1, 0, 0, 0);
    send_word(FUNC_POP_BACK, 0, 0, 0);
    send_word(FUNC_POP_FRONT, 0, 0, 0);
    send_word(FUNC_LIST, 0, 0, 0);
    send_word(FUNC_POP_FRONT, 0, 0, 0);
    send_word(FUNC_POP_BACK, 0, 0, 0);
    send_word(FUNC_POP_BACK, 0, 0, 0);
    send_word(FUNC_PUSH_FRONT, 32'sh1234_5678, 32'hdead_beef, 34'd5551234567);
    send_word(FUNC_PUSH_BACK, -32'sd42, 32'h8000_0000, 34'h2_0000_0000);
    send_word(FUNC_POP_FRONT, 0, 0, 0);
    send_word(FUNC_LIST, 0, 0, 0);

    while (items_sent < N_ITEMS) begin
      case ($urandom_range(0, 2))
        0: begin
          while (level < RdqDepth) begin
            roll = $urandom_range(0, 99);
            if (roll < 85) push_any();
            else if (roll < 92) pop_any();
            else send_random(FUNC_LIST);
          end
          repeat ($urandom_range(1, 3)) push_any();
          send_random(FUNC_LIST);
        end
        1: begin
          while (level > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 85) pop_any();
            else if (roll < 93) push_any();
            else send_random(FUNC_LIST);
          end
          repeat ($urandom_range(1, 2)) pop_any();
          send_random(FUNC_LIST);
        end
        default: begin
          repeat ($urandom_range(10, 30)) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) push_any();
            else if (roll < 80) pop_any();
            else if (roll < 92) send_random(FUNC_LIST);
            else send_random(3'($urandom_range(FUNC_UNUSED_FIRST, FUNC_UNUSED_LAST)));
          end
        end
      endcase
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
